/* hw/rtl/sgdm_pkg.sv */
// Shared types, constants and fixed-point helpers for the SGD momentum update block.
// No dependencies; every other file in hw/rtl imports this package.
package sgdm_pkg;

    // Field widths
    localparam int IDX_W  = 10;
    localparam int VAL_W  = 32;
    localparam int COEF_W = 18;
    localparam int CNT_W  = 32;
    // Signed product of a zero-extended coefficient and a value
    localparam int PROD_W = COEF_W + 1 + VAL_W;

    // Decoupling queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int QP_W    = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MOMENTUM  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_L2_DECAY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NESTEROV  = 2'd3;

    localparam logic [COEF_W-1:0] STEP_SIZE_RESET = 18'd655;

    // Commands
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic                     command;
        logic [IDX_W-1:0]         element_index;
        logic signed [VAL_W-1:0]  param_value;
        logic signed [VAL_W-1:0]  gradient;
        logic                     last_in_step;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]         result_index;
        logic signed [VAL_W-1:0]  updated_param;
        logic [CNT_W-1:0]         steps_done;
    } t_out_item;

    typedef struct packed {
        logic [COEF_W-1:0] step_size;
        logic [COEF_W-1:0] momentum;
        logic [COEF_W-1:0] l2_decay;
        logic              nesterov_mode;
    } t_cfg;

    // Classified work item handed from front to back
    typedef struct packed {
        logic                     clr;
        logic [IDX_W-1:0]         idx;
        logic                     inr;
        logic                     last;
        logic signed [VAL_W-1:0]  param;
        logic signed [VAL_W-1:0]  gd;
    } t_task;

    // Shift a product right by frac bits, rounding half up, and clamp to VAL_W bits
    function automatic logic signed [VAL_W-1:0] round_sat(
        input logic signed [PROD_W-1:0] p,
        input int                       frac
    );
        logic signed [PROD_W-1:0] half;
        logic signed [PROD_W-1:0] sh;
        logic signed [VAL_W-1:0]  res;
        half = PROD_W'(1) << (frac - 1);
        sh   = (p + half) >>> frac;
        if (sh[PROD_W-1:VAL_W-1] == '0 || sh[PROD_W-1:VAL_W-1] == '1) begin
            res = sh[VAL_W-1:0];
        end else if (sh[PROD_W-1]) begin
            res = VAL_MIN;
        end else begin
            res = VAL_MAX;
        end
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0]          s;
        logic signed [VAL_W-1:0] res;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            res = s[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            res = s[VAL_W-1:0];
        end
        return res;
    endfunction

    function automatic logic signed [VAL_W-1:0] sat_sub(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0]          s;
        logic signed [VAL_W-1:0] res;
        s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            res = s[VAL_W] ? VAL_MIN : VAL_MAX;
        end else begin
            res = s[VAL_W-1:0];
        end
        return res;
    endfunction

endpackage

/* hw/rtl/sgd_momentum_param_update.sv */
// SGD parameter update with momentum, Nesterov lookahead and L2 weight decay, Q16.16.
// Instantiates sgdm_front, sgdm_queue and sgdm_back; depends on sgdm_pkg.
//
// One parameter element per beat, one result per beat, in order. The block sustains one beat
// per clock unless the output stalls, a same-element hold or a clearing sweep intervenes; a
// result is valid once its beat has passed the front register, the queue slot, six back
// stages and the output register. Two update beats back to back on the same element with
// momentum enabled insert a bubble, since the velocity read-modify-write (momentum multiply,
// then round and add) closes through the B3 forwarding register. After reset, and after each
// clear command, the velocity store is swept to zero one entry per cycle, min(NUM_ELEMENTS,
// 1024) entries, during which no input beat is taken. Configuration is written through its
// own port, which is always ready, and must only be written while the block is idle.
module sgd_momentum_param_update #(
    parameter int NUM_ELEMENTS = 1024,
    parameter int FRAC_BITS    = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  sgdm_pkg::t_in_item                i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output sgdm_pkg::t_out_item               o_out_data,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [sgdm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sgdm_pkg::COEF_W-1:0]       i_cfg_data
);
    import sgdm_pkg::*;

    t_cfg  r_cfg;
    logic  q_push;
    t_task q_push_data;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    t_task q_head;
    logic  sweep_busy;

    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size     <= STEP_SIZE_RESET;
            r_cfg.momentum      <= '0;
            r_cfg.l2_decay      <= '0;
            r_cfg.nesterov_mode <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP_SIZE: r_cfg.step_size     <= i_cfg_data;
                CFG_MOMENTUM:  r_cfg.momentum      <= i_cfg_data;
                CFG_L2_DECAY:  r_cfg.l2_decay      <= i_cfg_data;
                CFG_NESTEROV:  r_cfg.nesterov_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    sgdm_front #(
        .NUM_ELEMENTS (NUM_ELEMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_sweep_busy (sweep_busy),
        .i_q_full     (q_full),
        .o_q_push     (q_push),
        .o_q_data     (q_push_data)
    );

    sgdm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_valid     (q_valid),
        .o_head      (q_head)
    );

    sgdm_back #(
        .NUM_ELEMENTS (NUM_ELEMENTS),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_q_valid    (q_valid),
        .i_q_head     (q_head),
        .o_q_pop      (q_pop),
        .o_sweep_busy (sweep_busy),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_data   (o_out_data)
    );

endmodule

/* hw/rtl/sgdm_front.sv */
// Front end: accepts input beats, classifies them and applies weight decay.
// Depends on sgdm_pkg; feeds sgdm_queue.
module sgdm_front #(
    parameter int NUM_ELEMENTS = 1024,
    parameter int FRAC_BITS    = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sgdm_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sgdm_pkg::t_in_item i_in_data,
    input  logic              i_sweep_busy,
    input  logic              i_q_full,
    output logic              o_q_push,
    output sgdm_pkg::t_task   o_q_data
);
    import sgdm_pkg::*;

    logic                     r_s1_vld;
    t_in_item                 r_s1;
    logic signed [PROD_W-1:0] r_s1_prod;
    logic                     accept;
    logic signed [PROD_W-1:0] wd_prod;
    logic signed [VAL_W-1:0]  gd;

    // Stall while a full queue holds the front register and while the velocity store is being cleared
    assign o_in_ready = (!r_s1_vld || !i_q_full) && !i_sweep_busy;
    assign accept     = i_in_valid && o_in_ready;
    assign o_q_push   = r_s1_vld && !i_q_full;

    assign wd_prod = $signed({1'b0, i_cfg.l2_decay}) * i_in_data.param_value;

    // Add the decay term to the gradient when decay is enabled
    always_comb begin
        if (i_cfg.l2_decay != '0) begin
            gd = sat_add(r_s1.gradient, round_sat(r_s1_prod, FRAC_BITS));
        end else begin
            gd = r_s1.gradient;
        end
        o_q_data.clr   = (r_s1.command == CMD_CLEAR);
        o_q_data.idx   = r_s1.element_index;
        o_q_data.inr   = (32'(r_s1.element_index) < NUM_ELEMENTS);
        o_q_data.last  = r_s1.last_in_step;
        o_q_data.param = r_s1.param_value;
        o_q_data.gd    = gd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (accept) begin
            r_s1_vld <= 1'b1;
        end else if (o_q_push) begin
            r_s1_vld <= 1'b0;
        end
    end

    // Capture the beat and its decay product
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1      <= i_in_data;
            r_s1_prod <= wd_prod;
        end
    end

endmodule

/* hw/rtl/sgdm_queue.sv */
// Short FIFO of classified work items between front and back.
// Depends on sgdm_pkg.
module sgdm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sgdm_pkg::t_task i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output sgdm_pkg::t_task o_head
);
    import sgdm_pkg::*;

    t_task           r_slot [Q_DEPTH];
    logic [QP_W-1:0] r_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr;
    logic [QP_W:0]   r_cnt;

    assign o_full  = (r_cnt == (QP_W+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_slot[r_rd_ptr];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QP_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QP_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QP_W+1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QP_W+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* hw/rtl/sgdm_back.sv */
// Back end: velocity store, momentum / Nesterov / step-size pipeline, step counter.
// Depends on sgdm_pkg; pops sgdm_queue and drives the result channel.
module sgdm_back #(
    parameter int NUM_ELEMENTS = 1024,
    parameter int FRAC_BITS    = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sgdm_pkg::t_cfg      i_cfg,
    input  logic                i_q_valid,
    input  sgdm_pkg::t_task     i_q_head,
    output logic                o_q_pop,
    output logic                o_sweep_busy,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output sgdm_pkg::t_out_item o_out_data
);
    import sgdm_pkg::*;

    localparam int MEM_DEPTH = (NUM_ELEMENTS < (1 << IDX_W)) ? NUM_ELEMENTS : (1 << IDX_W);
    localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

    // Velocity store
    logic signed [VAL_W-1:0] r_vmem [MEM_DEPTH];
    logic signed [VAL_W-1:0] r_b1_rd;

    // Clearing sweep
    logic          r_sweep;
    logic [AW-1:0] r_swp_addr;

    // Pipeline stages
    logic r_b1_vld, r_b2_vld, r_b3_vld, r_b4_vld, r_b5_vld, r_b6_vld, r_ov;
    t_task r_b1, r_b2, r_b3, r_b4, r_b5, r_b6;
    logic signed [PROD_W-1:0] r_b2_prod, r_b4_prod, r_b6_prod;
    logic signed [VAL_W-1:0]  r_b3_vel, r_b4_vel, r_b5_g;
    logic [CNT_W-1:0]         r_steps;
    t_out_item                r_out;

    logic                     mom_on;
    logic                     adv;
    logic                     hazard;
    logic                     clr_wait;
    logic                     pop;
    logic                     fwd;
    logic signed [VAL_W-1:0]  vold;
    logic signed [PROD_W-1:0] prod1, prod3, prod5;
    logic signed [VAL_W-1:0]  vel_new;
    logic signed [VAL_W-1:0]  g;
    logic signed [VAL_W-1:0]  newp;
    logic [CNT_W-1:0]         steps_nxt;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [VAL_W-1:0]  wr_data;

    assign mom_on = (i_cfg.momentum != '0);
    // Whole back pipeline moves when the output register can take a beat
    assign adv    = !r_ov || i_out_ready;

    // Hold a same-index update so the earlier update's velocity can be forwarded from B3
    assign hazard = mom_on && r_b1_vld && !r_b1.clr && r_b1.inr
                 && !i_q_head.clr && i_q_head.inr && (r_b1.idx == i_q_head.idx);
    // Hold a clear until no earlier velocity write is pending
    assign clr_wait = i_q_head.clr && (r_b1_vld || r_b2_vld);
    assign pop      = adv && i_q_valid && !r_sweep && !hazard && !clr_wait;

    assign o_q_pop      = pop;
    assign o_sweep_busy = r_sweep;
    assign o_out_valid  = r_ov;
    assign o_out_data   = r_out;

    // B1: select old velocity, multiply by momentum
    assign fwd  = r_b3_vld && !r_b3.clr && r_b3.inr && (r_b3.idx == r_b1.idx);
    always_comb begin
        if (!r_b1.inr) begin
            vold = '0;
        end else if (fwd) begin
            vold = r_b3_vel;
        end else begin
            vold = r_b1_rd;
        end
    end
    assign prod1 = $signed({1'b0, i_cfg.momentum}) * vold;

    // B2: new velocity
    assign vel_new = sat_add(round_sat(r_b2_prod, FRAC_BITS), r_b2.gd);

    // B3: Nesterov lookahead product
    assign prod3 = $signed({1'b0, i_cfg.momentum}) * r_b3_vel;

    // B4: pick the applied gradient
    always_comb begin
        if (!mom_on) begin
            g = r_b4.gd;
        end else if (i_cfg.nesterov_mode) begin
            g = sat_add(r_b4.gd, round_sat(r_b4_prod, FRAC_BITS));
        end else begin
            g = r_b4_vel;
        end
    end

    // B5: step-size product
    assign prod5 = $signed({1'b0, i_cfg.step_size}) * r_b5_g;

    // B6: new parameter and step count
    always_comb begin
        if (r_b6.clr) begin
            newp      = r_b6.param;
            steps_nxt = '0;
        end else begin
            newp      = sat_sub(r_b6.param, round_sat(r_b6_prod, FRAC_BITS));
            steps_nxt = r_b6.last ? (r_steps + CNT_W'(1)) : r_steps;
        end
    end

    // Memory write port: sweep has priority, else the B2 velocity write-back
    always_comb begin
        if (r_sweep) begin
            wr_en   = 1'b1;
            wr_addr = r_swp_addr;
            wr_data = '0;
        end else begin
            wr_en   = adv && r_b2_vld && !r_b2.clr && r_b2.inr && mom_on;
            wr_addr = AW'(r_b2.idx);
            wr_data = vel_new;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_vmem[wr_addr] <= wr_data;
        end
        if (pop) begin
            r_b1_rd <= r_vmem[AW'(i_q_head.idx)];
        end
    end

    // Control: stage valids, step counter, clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_vld   <= 1'b0;
            r_b2_vld   <= 1'b0;
            r_b3_vld   <= 1'b0;
            r_b4_vld   <= 1'b0;
            r_b5_vld   <= 1'b0;
            r_b6_vld   <= 1'b0;
            r_ov       <= 1'b0;
            r_steps    <= '0;
            r_sweep    <= 1'b1;
            r_swp_addr <= '0;
        end else begin
            if (adv) begin
                r_b1_vld <= pop;
                r_b2_vld <= r_b1_vld;
                r_b3_vld <= r_b2_vld;
                r_b4_vld <= r_b3_vld;
                r_b5_vld <= r_b4_vld;
                r_b6_vld <= r_b5_vld;
                r_ov     <= r_b6_vld;
                if (r_b6_vld) begin
                    r_steps <= steps_nxt;
                end
            end
            if (r_sweep) begin
                if (r_swp_addr == LAST_ADDR) begin
                    r_sweep <= 1'b0;
                end
                r_swp_addr <= r_swp_addr + AW'(1);
            end else if (pop && i_q_head.clr) begin
                r_sweep    <= 1'b1;
                r_swp_addr <= '0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b1      <= i_q_head;
            r_b2      <= r_b1;
            r_b2_prod <= prod1;
            r_b3      <= r_b2;
            r_b3_vel  <= vel_new;
            r_b4      <= r_b3;
            r_b4_vel  <= r_b3_vel;
            r_b4_prod <= prod3;
            r_b5      <= r_b4;
            r_b5_g    <= g;
            r_b6      <= r_b5;
            r_b6_prod <= prod5;
            if (r_b6_vld) begin
                r_out.result_index  <= r_b6.idx;
                r_out.updated_param <= newp;
                r_out.steps_done    <= steps_nxt;
            end
        end
    end

endmodule
